>>> sv/led_status_indicator_assert.svh
// Assertion helpers for the LED status indicator.
// Each macro checks one implication on the rising edge of i_clk and is
// disabled while i_rst_n is low.
`ifndef LED_STATUS_INDICATOR_ASSERT_SVH
`define LED_STATUS_INDICATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define LSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LSI_ASSERT_NOW(lbl, ante, cons, msg)
`define LSI_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/lsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsi_pkg;

    // Item operations
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_BATTERY   = 2'd1;
    localparam logic [1:0] OP_FAULT     = 2'd2;
    localparam logic [1:0] OP_BREATHING = 2'd3;

    // Display modes
    localparam logic [1:0] MODE_BATTERY   = 2'd0;
    localparam logic [1:0] MODE_BREATHING = 2'd1;
    localparam logic [1:0] MODE_FAULT     = 2'd2;

    // Register indexes
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 12;
    localparam logic [CfgIdxW-1:0] REG_BLINK_HALF = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PAUSE_LEN  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PULSES     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_THR_FOUR   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_THR_THREE  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_THR_TWO    = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_THR_ONE    = 3'd6;

    // Register reset values
    localparam logic [9:0]  RST_BLINK_HALF = 10'd250;
    localparam logic [11:0] RST_PAUSE_LEN  = 12'd1000;
    localparam logic [3:0]  RST_PULSES     = 4'd2;
    localparam logic [6:0]  RST_THR_FOUR   = 7'd80;
    localparam logic [6:0]  RST_THR_THREE  = 7'd55;
    localparam logic [6:0]  RST_THR_TWO    = 7'd30;
    localparam logic [6:0]  RST_THR_ONE    = 7'd10;

    localparam logic [7:0]  DUTY_FULL     = 8'd255;
    localparam logic [7:0]  DUTY_OFF      = 8'd0;
    localparam logic [6:0]  BATTERY_MAX   = 7'd100;
    localparam logic [9:0]  BLINK_SAT     = 10'd1023;
    localparam logic [11:0] PAUSE_SAT     = 12'd4095;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] led_one_duty;
        logic [7:0] led_two_duty;
        logic [7:0] led_three_duty;
        logic [7:0] led_four_duty;
        logic [1:0] display_mode;
    } t_out_item;

endpackage

`default_nettype wire

>>> sv/led_status_indicator.sv
`timescale 1ns / 1ps
`default_nettype none
//  Channel  | Direction | Handshake                    | Beat
//  ---------+-----------+------------------------------+-----------------------------
//  input    | in        | i_valid / o_stall            | t_in_item  (operation, value)
//  result   | out       | o_valid / i_stall            | t_out_item (four duties, mode)
//  config   | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  One beat in per cycle while o_stall is low, one result beat out per input
//  beat: input register, then the tick/command logic into the result register.
//  Reset (i_rst_n low at a clock edge) clears both stages, the display state and
//  loads the register defaults. o_stall rises only when the input stage holds a
//  beat and the result register is full and stalled; config is always ready.

module led_status_indicator
    import lsi_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input items
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire t_in_item            i_in,
    // result items
    output logic                     o_valid,
    input  wire logic                i_stall,
    output t_out_item                o_out,
    // register writes
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [9:0]  r_blink_half;
    logic [11:0] r_pause_len;
    logic [3:0]  r_pulses;
    logic [6:0]  r_thr_four;
    logic [6:0]  r_thr_three;
    logic [6:0]  r_thr_two;
    logic [6:0]  r_thr_one;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_half <= RST_BLINK_HALF;
            r_pause_len  <= RST_PAUSE_LEN;
            r_pulses     <= RST_PULSES;
            r_thr_four   <= RST_THR_FOUR;
            r_thr_three  <= RST_THR_THREE;
            r_thr_two    <= RST_THR_TWO;
            r_thr_one    <= RST_THR_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            // Unknown indexes drop silently.
            unique case (i_cfg_index)
                REG_BLINK_HALF: r_blink_half <= i_cfg_data[9:0];
                REG_PAUSE_LEN:  r_pause_len  <= i_cfg_data;
                REG_PULSES:     r_pulses     <= i_cfg_data[3:0];
                REG_THR_FOUR:   r_thr_four   <= i_cfg_data[6:0];
                REG_THR_THREE:  r_thr_three  <= i_cfg_data[6:0];
                REG_THR_TWO:    r_thr_two    <= i_cfg_data[6:0];
                REG_THR_ONE:    r_thr_one    <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: input register -> result register
    // ------------------------------------------------------------------
    logic     r_in_valid;
    t_in_item r_in;
    logic     r_out_valid;
    t_out_item r_out;

    logic out_free;   // result register can take a beat this cycle
    logic advance;    // input stage moves into the result register
    logic take;       // a new input beat is accepted

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign take     = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= take || (r_in_valid && !advance);
            r_out_valid <= advance || (r_out_valid && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_in;
        end
    end

    // ------------------------------------------------------------------
    // Display state
    // ------------------------------------------------------------------
    logic [7:0]  r_duty [4];
    logic [6:0]  r_battery;
    logic        r_fault;
    logic        r_breath;
    logic        r_blink_phase;
    logic [9:0]  r_blink_elapsed;
    logic [7:0]  r_glow_level;
    logic        r_glow_rising;
    logic [3:0]  r_pulse_tally;
    logic        r_pausing;
    logic [11:0] r_pause_elapsed;

    logic [7:0]  n_duty [4];
    logic [6:0]  n_battery;
    logic        n_fault;
    logic        n_breath;
    logic        n_blink_phase;
    logic [9:0]  n_blink_elapsed;
    logic [7:0]  n_glow_level;
    logic        n_glow_rising;
    logic [3:0]  n_pulse_tally;
    logic        n_pausing;
    logic [11:0] n_pause_elapsed;

    logic        flag;
    logic [2:0]  bar_count;     // LEDs lit by the battery bar graph
    logic [7:0]  glow_down;
    logic [3:0]  tally_up;
    t_out_item   n_out;

    assign flag = r_in.value[0];

    // Bar graph level: highest threshold met wins.
    always_comb begin
        if (r_battery >= r_thr_four) begin
            bar_count = 3'd4;
        end else if (r_battery >= r_thr_three) begin
            bar_count = 3'd3;
        end else if (r_battery >= r_thr_two) begin
            bar_count = 3'd2;
        end else if (r_battery >= r_thr_one) begin
            bar_count = 3'd1;
        end else begin
            bar_count = 3'd0;
        end
    end

    assign glow_down = (r_glow_level != 8'd0) ? r_glow_level - 8'd1 : 8'd0;
    assign tally_up  = r_pulse_tally + 4'd1;

    always_comb begin
        n_duty          = r_duty;
        n_battery       = r_battery;
        n_fault         = r_fault;
        n_breath        = r_breath;
        n_blink_phase   = r_blink_phase;
        n_blink_elapsed = r_blink_elapsed;
        n_glow_level    = r_glow_level;
        n_glow_rising   = r_glow_rising;
        n_pulse_tally   = r_pulse_tally;
        n_pausing       = r_pausing;
        n_pause_elapsed = r_pause_elapsed;

        unique case (r_in.operation)
            OP_TICK: begin
                // Advance both elapsed counters on every tick, saturating.
                if (r_blink_elapsed != BLINK_SAT) begin
                    n_blink_elapsed = r_blink_elapsed + 10'd1;
                end
                if (r_pause_elapsed != PAUSE_SAT) begin
                    n_pause_elapsed = r_pause_elapsed + 12'd1;
                end

                if (r_fault) begin
                    // Toggle the blink once the half period has gone by.
                    if (n_blink_elapsed >= r_blink_half) begin
                        n_blink_elapsed = 10'd0;
                        n_blink_phase   = !r_blink_phase;
                        for (int i = 0; i < 4; i++) begin
                            n_duty[i] = n_blink_phase ? DUTY_FULL : DUTY_OFF;
                        end
                    end
                end else if (r_breath) begin
                    // Hold dark until the pause runs out, then step in the same tick.
                    if (!r_pausing || (n_pause_elapsed >= r_pause_len)) begin
                        n_pausing = 1'b0;
                        if (r_glow_rising) begin
                            n_glow_level = r_glow_level + 8'd1;
                            if (n_glow_level == DUTY_FULL) begin
                                n_glow_rising = 1'b0;
                            end
                        end else begin
                            n_glow_level = glow_down;
                            if (glow_down == 8'd0) begin
                                // Bottom of a pulse: count it, maybe start a pause.
                                n_glow_rising = 1'b1;
                                n_pulse_tally = tally_up;
                                if (tally_up >= r_pulses) begin
                                    n_pulse_tally   = 4'd0;
                                    n_pausing       = 1'b1;
                                    n_pause_elapsed = 12'd0;
                                end
                            end
                        end
                        for (int i = 0; i < 4; i++) begin
                            n_duty[i] = n_glow_level;
                        end
                    end
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        n_duty[i] = (3'(i) < bar_count) ? DUTY_FULL : DUTY_OFF;
                    end
                end
            end
            OP_BATTERY: begin
                n_battery = (r_in.value > 8'(BATTERY_MAX)) ? BATTERY_MAX : r_in.value[6:0];
            end
            OP_FAULT: begin
                n_fault = flag;
                if (!flag) begin
                    n_blink_phase = 1'b0;
                    for (int i = 0; i < 4; i++) begin
                        n_duty[i] = DUTY_OFF;
                    end
                end
            end
            OP_BREATHING: begin
                n_breath = flag;
                if (flag) begin
                    // Restart the ramp from dark.
                    n_glow_level  = 8'd0;
                    n_glow_rising = 1'b1;
                    n_pulse_tally = 4'd0;
                    n_pausing     = 1'b0;
                end
                for (int i = 0; i < 4; i++) begin
                    n_duty[i] = DUTY_OFF;
                end
            end
            default: ;
        endcase

        n_out.led_one_duty   = n_duty[0];
        n_out.led_two_duty   = n_duty[1];
        n_out.led_three_duty = n_duty[2];
        n_out.led_four_duty  = n_duty[3];
        n_out.display_mode   = n_fault  ? MODE_FAULT :
                               n_breath ? MODE_BREATHING : MODE_BATTERY;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_duty[i] <= DUTY_OFF;
            end
            r_battery       <= 7'd0;
            r_fault         <= 1'b0;
            r_breath        <= 1'b0;
            r_blink_phase   <= 1'b0;
            r_blink_elapsed <= 10'd0;
            r_glow_level    <= 8'd0;
            r_glow_rising   <= 1'b1;
            r_pulse_tally   <= 4'd0;
            r_pausing       <= 1'b0;
            r_pause_elapsed <= 12'd0;
        end else if (advance) begin
            r_duty          <= n_duty;
            r_battery       <= n_battery;
            r_fault         <= n_fault;
            r_breath        <= n_breath;
            r_blink_phase   <= n_blink_phase;
            r_blink_elapsed <= n_blink_elapsed;
            r_glow_level    <= n_glow_level;
            r_glow_rising   <= n_glow_rising;
            r_pulse_tally   <= n_pulse_tally;
            r_pausing       <= n_pausing;
            r_pause_elapsed <= n_pause_elapsed;
        end
    end

    // Result register: load when the input stage advances, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "led_status_indicator_assert.svh"

    `LSI_ASSERT_NOW(a_stall_needs_item, o_stall, r_in_valid && r_out_valid, "stall with no blocked beat")
    `LSI_ASSERT_NOW(a_battery_clamped, 1'b1, r_battery <= BATTERY_MAX, "battery level above clamp")
    `LSI_ASSERT_NOW(a_glow_turns, r_glow_level == DUTY_FULL || r_glow_level == 8'd0, r_glow_rising == (r_glow_level == 8'd0), "ramp direction wrong at an end")
    `LSI_ASSERT_NEXT(a_blocked_result_kept, r_out_valid && i_stall, r_out_valid, "result dropped while stalled")

endmodule

`default_nettype wire
